// ===== hdl/hlpi_pkg.sv =====
// ----------------------------------------------------------------------------
// hlpi_pkg
// Shared types and constants for the polar line pair intersection unit.
// ----------------------------------------------------------------------------
package hlpi_pkg;

    // angle constants
    localparam logic [16:0] PI_Q14      = 17'd51472;
    localparam logic [31:0] PI_Q30      = 32'd3373259426;
    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
    localparam logic [30:0] ONE_Q30     = 31'd1073741824;

    localparam logic [15:0] MIN_THETA_RESET = 16'd1608;

    // register map: word index taken from paddr[2]
    localparam logic [0:0] ADDR_MIN_THETA = 1'b0;

    // Taylor steps: sine runs to x^15, cosine to x^16
    localparam int SIN_STEPS = 7;
    localparam int COS_STEPS = 8;

    // sincos pipe stages: two folds, square, three per Taylor cell, two for rounding
    localparam int TRIG_LAT  = 3 + 3 * COS_STEPS + 2;
    // quotient bits produced by the divide chain
    localparam int DIV_STEPS = 34;

    // factorial steps and ceil(2^32 / divisor)
    localparam logic [7:0]  SIN_DIV   [1:8] = '{8'd6, 8'd20, 8'd42, 8'd72, 8'd110,
                                                8'd156, 8'd210, 8'd1};
    localparam logic [31:0] SIN_RECIP [1:8] = '{32'd715827883, 32'd214748365,
                                                32'd102261127, 32'd59652324,
                                                32'd39045158, 32'd27531842,
                                                32'd20452226, 32'd0};
    localparam logic [7:0]  COS_DIV   [1:8] = '{8'd2, 8'd12, 8'd30, 8'd56, 8'd90,
                                                8'd132, 8'd182, 8'd240};
    localparam logic [31:0] COS_RECIP [1:8] = '{32'd2147483648, 32'd357913942,
                                                32'd143165577, 32'd76695845,
                                                32'd47721859, 32'd32537632,
                                                32'd23598722, 32'd17895698};

    // one sample moving down the Taylor cell chain (Q30)
    typedef struct packed {
        logic [31:0]        x2;
        logic [30:0]        term_s;
        logic [30:0]        term_c;
        logic signed [33:0] sum_s;
        logic signed [33:0] sum_c;
        logic               sneg;
        logic               cneg;
    } taylor_t;

    // request sideband held while the trig runs
    typedef struct packed {
        logic               rej;
        logic [16:0]        ea;
        logic [16:0]        eb;
        logic signed [15:0] ra;
        logic signed [15:0] rb;
    } side_t;

    // status carried through the divide chain
    typedef struct packed {
        logic rej;
        logic zero;
        logic negx;
        logic negy;
        logic ovx;
        logic ovy;
    } solve_flags_t;

endpackage

// ===== hdl/hlpi_pair_if.sv =====
// ----------------------------------------------------------------------------
// hlpi_pair_if
// Line pair request channel: two lines in polar form.
// ----------------------------------------------------------------------------
interface hlpi_pair_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] rho_a;
    logic [15:0]        theta_a;
    logic signed [15:0] rho_b;
    logic [15:0]        theta_b;

    modport source (output valid, output rho_a, output theta_a, output rho_b,
                    output theta_b, input ready);
    modport sink   (input valid, input rho_a, input theta_a, input rho_b,
                    input theta_b, output ready);
endinterface

// ===== hdl/hlpi_point_if.sv =====
// ----------------------------------------------------------------------------
// hlpi_point_if
// Intersection result channel.
// ----------------------------------------------------------------------------
interface hlpi_point_if;
    logic               valid;
    logic               ready;
    logic               accepted;
    logic signed [31:0] cross_x;
    logic signed [31:0] cross_y;
    logic               saturated;

    modport source (output valid, output accepted, output cross_x, output cross_y,
                    output saturated, input ready);
    modport sink   (input valid, input accepted, input cross_x, input cross_y,
                    input saturated, output ready);
endinterface

// ===== hdl/hough_line_pair_intersect_unit.sv =====
// ----------------------------------------------------------------------------
// hough_line_pair_intersect_unit
// Intersection point of two Hough lines given as (rho, theta).
// ----------------------------------------------------------------------------
// A fully pipelined unit: one line pair request is taken every cycle while the
// pipe does not hold, and each produces exactly one result after 68 pipeline
// stages and the output register. Sine and cosine of each angle run through a
// chain of eight Taylor cells, three stages per cell; the two coordinates are
// then solved by Cramer's rule and divided in a chain of 34 restoring divide
// cells, one quotient bit per cell. The whole pipe advances together; it holds
// only when a result sits in the output register, the consumer does not take
// it, and the last stage carries another one. A pair whose angles (each raised
// by pi when below min_theta) differ by no more than min_theta gives
// accepted=0, zero coordinates and saturated=0; parallel lines give accepted=0
// and saturated=1; a coordinate out of the signed 32-bit range is clamped and
// flags saturated. min_theta sits at byte address 0 of the APB port and must
// only be written while the unit is empty.
// ----------------------------------------------------------------------------
module hough_line_pair_intersect_unit
    import hlpi_pkg::*;
#(
    parameter int TRIG_FRAC_BITS = 14
)
(
    input  logic         clk,
    input  logic         rst_n,
    hlpi_pair_if.sink    pair,
    hlpi_point_if.source point,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int F         = TRIG_FRAC_BITS;
    localparam int SC_W      = F + 2;            // signed sin/cos
    localparam int PD_W      = 2 * SC_W;         // sin*cos product
    localparam int PN_W      = 16 + SC_W;        // rho*trig product
    localparam int DW        = PD_W + 1;         // denominator / its magnitude
    localparam int NW        = PN_W + 1;         // numerator / its magnitude
    localparam int OUT_SHIFT = 8 + F;
    localparam int NPW       = NW + OUT_SHIFT + 1; // dividend, one extra bit for rounding
    localparam int QW        = DIV_STEPS;
    localparam int PIPE_LEN  = TRIG_LAT + 5 + DIV_STEPS;
    localparam int LAST      = PIPE_LEN - 1;

    // ------------------------------------------------------------------
    // config register
    // ------------------------------------------------------------------
    logic [15:0] min_theta_reg;
    logic        cfg_hit;

    assign cfg_hit = (paddr[2:2] == ADDR_MIN_THETA);
    assign pready  = 1'b1;
    assign prdata  = cfg_hit ? {16'h0000, min_theta_reg} : 32'h0000_0000;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_theta_reg <= MIN_THETA_RESET;
        else if (psel && penable && pwrite && pready && cfg_hit)
            min_theta_reg <= pwdata[15:0];
    end

    // ------------------------------------------------------------------
    // pipeline control: everything advances together
    // ------------------------------------------------------------------
    logic [PIPE_LEN-1:0] vld_reg;
    logic                out_valid_reg;
    logic                adv;
    logic                out_load;

    assign adv        = !vld_reg[LAST] || !out_valid_reg || point.ready;
    assign out_load   = !out_valid_reg || point.ready;
    assign pair.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
                vld_reg <= {vld_reg[PIPE_LEN-2:0], pair.valid};
            if (out_load)
                out_valid_reg <= vld_reg[LAST];
        end
    end

    // ------------------------------------------------------------------
    // angle test and sideband, aligned with the sincos pipes
    // ------------------------------------------------------------------
    side_t       side_reg [0:TRIG_LAT-1];
    logic [16:0] ea_in, eb_in;
    logic [16:0] d_ab, d_ba, diff;

    assign ea_in = (pair.theta_a < min_theta_reg) ? 17'(pair.theta_a) + PI_Q14
                                                  : 17'(pair.theta_a);
    assign eb_in = (pair.theta_b < min_theta_reg) ? 17'(pair.theta_b) + PI_Q14
                                                  : 17'(pair.theta_b);
    assign d_ab  = side_reg[0].ea - side_reg[0].eb;
    assign d_ba  = side_reg[0].eb - side_reg[0].ea;
    assign diff  = (side_reg[0].ea > side_reg[0].eb) ? d_ab : d_ba;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0].rej <= 1'b0;
            side_reg[0].ea  <= ea_in;
            side_reg[0].eb  <= eb_in;
            side_reg[0].ra  <= pair.rho_a;
            side_reg[0].rb  <= pair.rho_b;
            side_reg[1].rej <= (diff <= 17'(min_theta_reg));
            side_reg[1].ea  <= side_reg[0].ea;
            side_reg[1].eb  <= side_reg[0].eb;
            side_reg[1].ra  <= side_reg[0].ra;
            side_reg[1].rb  <= side_reg[0].rb;
            for (int i = 2; i < TRIG_LAT; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    logic signed [SC_W-1:0] sa, ca, sb, cb;

    hlpi_sincos #(.FRAC(F)) u_trig_a (
        .clk     (clk),
        .adv     (adv),
        .theta   (pair.theta_a),
        .sin_val (sa),
        .cos_val (ca)
    );

    hlpi_sincos #(.FRAC(F)) u_trig_b (
        .clk     (clk),
        .adv     (adv),
        .theta   (pair.theta_b),
        .sin_val (sb),
        .cos_val (cb)
    );

    // ------------------------------------------------------------------
    // Cramer's rule: products, sums, magnitudes, divide setup
    // ------------------------------------------------------------------
    logic signed [PD_W-1:0] pd1_reg, pd2_reg;
    logic signed [PN_W-1:0] px1_reg, px2_reg, py1_reg, py2_reg;
    logic                   rej1_reg, rej2_reg, rej3_reg;
    logic signed [DW-1:0]   den_reg;
    logic signed [NW-1:0]   nx_reg, ny_reg;
    logic [DW-1:0]          dm_reg;
    logic [NW-1:0]          nmx_reg, nmy_reg;
    logic                   zero3_reg, negx3_reg, negy3_reg;
    solve_flags_t           fl4_reg;
    logic [DW:0]            remx0_reg, remy0_reg;
    logic [QW-1:0]          numx0_reg, numy0_reg;
    logic [DW-1:0]          dm4_reg;

    logic [NPW-1:0]         npx, npy;
    logic [NPW-1:0]         topx, topy;

    assign npx  = NPW'(nmx_reg) << (OUT_SHIFT + 1);
    assign npy  = NPW'(nmy_reg) << (OUT_SHIFT + 1);
    assign topx = npx >> QW;
    assign topy = npy >> QW;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pd1_reg  <= ca * sb;
            pd2_reg  <= sa * cb;
            px1_reg  <= side_reg[TRIG_LAT-1].ra * sb;
            px2_reg  <= side_reg[TRIG_LAT-1].rb * sa;
            py1_reg  <= side_reg[TRIG_LAT-1].rb * ca;
            py2_reg  <= side_reg[TRIG_LAT-1].ra * cb;
            rej1_reg <= side_reg[TRIG_LAT-1].rej;

            den_reg  <= DW'(pd1_reg) - DW'(pd2_reg);
            nx_reg   <= NW'(px1_reg) - NW'(px2_reg);
            ny_reg   <= NW'(py1_reg) - NW'(py2_reg);
            rej2_reg <= rej1_reg;

            dm_reg    <= den_reg[DW-1] ? DW'(-den_reg) : DW'(den_reg);
            nmx_reg   <= nx_reg[NW-1] ? NW'(-nx_reg) : NW'(nx_reg);
            nmy_reg   <= ny_reg[NW-1] ? NW'(-ny_reg) : NW'(ny_reg);
            zero3_reg <= (den_reg == '0);
            negx3_reg <= nx_reg[NW-1] ^ den_reg[DW-1];
            negy3_reg <= ny_reg[NW-1] ^ den_reg[DW-1];
            rej3_reg  <= rej2_reg;

            // quotient must fit QW bits, else the coordinate is clamped anyway
            fl4_reg.rej  <= rej3_reg;
            fl4_reg.zero <= zero3_reg;
            fl4_reg.negx <= negx3_reg;
            fl4_reg.negy <= negy3_reg;
            fl4_reg.ovx  <= (topx >= NPW'(dm_reg));
            fl4_reg.ovy  <= (topy >= NPW'(dm_reg));
            remx0_reg    <= (DW+1)'(topx);
            remy0_reg    <= (DW+1)'(topy);
            numx0_reg    <= npx[QW-1:0];
            numy0_reg    <= npy[QW-1:0];
            dm4_reg      <= dm_reg;
        end
    end

    // ------------------------------------------------------------------
    // divide chains, one quotient bit per cell
    // ------------------------------------------------------------------
    logic [DW:0]   remx_w [0:DIV_STEPS];
    logic [DW:0]   remy_w [0:DIV_STEPS];
    logic [QW-1:0] numx_w [0:DIV_STEPS];
    logic [QW-1:0] numy_w [0:DIV_STEPS];
    logic [QW-1:0] quox_w [0:DIV_STEPS];
    logic [QW-1:0] quoy_w [0:DIV_STEPS];
    logic [DW-1:0] dmx_w  [0:DIV_STEPS];
    logic [DW-1:0] dmy_w  [0:DIV_STEPS];
    solve_flags_t  fl_reg [0:DIV_STEPS];

    assign remx_w[0] = remx0_reg;
    assign remy_w[0] = remy0_reg;
    assign numx_w[0] = numx0_reg;
    assign numy_w[0] = numy0_reg;
    assign quox_w[0] = '0;
    assign quoy_w[0] = '0;
    assign dmx_w[0]  = dm4_reg;
    assign dmy_w[0]  = dm4_reg;
    assign fl_reg[0] = fl4_reg;

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div
        hlpi_div_cell #(.DM_W(DW), .QW(QW)) u_div_x (
            .clk     (clk),
            .adv     (adv),
            .rem_in  (remx_w[i]),
            .num_in  (numx_w[i]),
            .quo_in  (quox_w[i]),
            .dm_in   (dmx_w[i]),
            .rem_out (remx_w[i+1]),
            .num_out (numx_w[i+1]),
            .quo_out (quox_w[i+1]),
            .dm_out  (dmx_w[i+1])
        );

        hlpi_div_cell #(.DM_W(DW), .QW(QW)) u_div_y (
            .clk     (clk),
            .adv     (adv),
            .rem_in  (remy_w[i]),
            .num_in  (numy_w[i]),
            .quo_in  (quoy_w[i]),
            .dm_in   (dmy_w[i]),
            .rem_out (remy_w[i+1]),
            .num_out (numy_w[i+1]),
            .quo_out (quoy_w[i+1]),
            .dm_out  (dmy_w[i+1])
        );

        always_ff @(posedge clk)
        begin
            if (adv)
                fl_reg[i+1] <= fl_reg[i];
        end
    end

    // ------------------------------------------------------------------
    // round half up (quotient carries one extra bit) and clamp
    // ------------------------------------------------------------------
    localparam logic [QW-1:0] POS_MAX = QW'(32'h7FFF_FFFF);
    localparam logic [QW-1:0] NEG_MAX = QW'(33'h0_8000_0000);

    solve_flags_t  flf_reg;
    logic [31:0]   cmx_reg, cmy_reg;
    logic          satx_reg, saty_reg;
    logic [QW:0]   rndx, rndy;
    logic [QW-1:0] magx, magy;
    logic          satx, saty;

    assign rndx = (QW+1)'(quox_w[DIV_STEPS]) + (QW+1)'(1);
    assign rndy = (QW+1)'(quoy_w[DIV_STEPS]) + (QW+1)'(1);
    assign magx = rndx[QW:1];
    assign magy = rndy[QW:1];
    assign satx = fl_reg[DIV_STEPS].ovx ||
                  (magx > (fl_reg[DIV_STEPS].negx ? NEG_MAX : POS_MAX));
    assign saty = fl_reg[DIV_STEPS].ovy ||
                  (magy > (fl_reg[DIV_STEPS].negy ? NEG_MAX : POS_MAX));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            flf_reg  <= fl_reg[DIV_STEPS];
            satx_reg <= satx;
            saty_reg <= saty;
            if (satx)
                cmx_reg <= fl_reg[DIV_STEPS].negx ? NEG_MAX[31:0] : POS_MAX[31:0];
            else
                cmx_reg <= magx[31:0];
            if (saty)
                cmy_reg <= fl_reg[DIV_STEPS].negy ? NEG_MAX[31:0] : POS_MAX[31:0];
            else
                cmy_reg <= magy[31:0];
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    logic               acc_reg, sat_reg;
    logic signed [31:0] x_reg, y_reg;

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (flf_reg.rej)
            begin
                acc_reg <= 1'b0;
                sat_reg <= 1'b0;
                x_reg   <= '0;
                y_reg   <= '0;
            end
            else if (flf_reg.zero)
            begin
                acc_reg <= 1'b0;
                sat_reg <= 1'b1;
                x_reg   <= '0;
                y_reg   <= '0;
            end
            else
            begin
                acc_reg <= 1'b1;
                sat_reg <= satx_reg || saty_reg;
                x_reg   <= flf_reg.negx ? $signed(-cmx_reg) : $signed(cmx_reg);
                y_reg   <= flf_reg.negy ? $signed(-cmy_reg) : $signed(cmy_reg);
            end
        end
    end

    assign point.valid     = out_valid_reg;
    assign point.accepted  = acc_reg;
    assign point.cross_x   = x_reg;
    assign point.cross_y   = y_reg;
    assign point.saturated = sat_reg;

endmodule

// ===== hdl/hlpi_trig_cell.sv =====
// ----------------------------------------------------------------------------
// hlpi_trig_cell
// One Taylor step for sine and cosine: term * x^2 >> 30, divide by factorial step.
// ----------------------------------------------------------------------------
module hlpi_trig_cell
    import hlpi_pkg::*;
#(
    parameter int STEP = 1
)
(
    input  logic    clk,
    input  logic    adv,
    input  taylor_t din,
    output taylor_t dout
);

    localparam bit          SIN_ON = (STEP <= SIN_STEPS);
    localparam bit          SUB    = ((STEP % 2) == 1);
    localparam logic [31:0] SIN_M  = SIN_RECIP[STEP];
    localparam logic [31:0] COS_M  = COS_RECIP[STEP];
    localparam logic [7:0]  SIN_K  = SIN_DIV[STEP];
    localparam logic [7:0]  COS_K  = COS_DIV[STEP];

    taylor_t     s1_reg;
    taylor_t     s2_reg;
    logic [31:0] ps1_reg, pc1_reg;
    logic [31:0] ps2_reg, pc2_reg;
    logic [31:0] qs_reg, qc_reg;

    logic [62:0] prod_s, prod_c;
    logic [63:0] est_s, est_c;
    logic [39:0] back_s, back_c;
    logic [31:0] qs_fix, qc_fix;

    // product against x^2, keep bits 61:30 (always below 2^32)
    assign prod_s = 63'(din.term_s) * 63'(din.x2);
    assign prod_c = 63'(din.term_c) * 63'(din.x2);

    // reciprocal estimate is exact or one high
    assign est_s  = 64'(ps1_reg) * 64'(SIN_M);
    assign est_c  = 64'(pc1_reg) * 64'(COS_M);

    assign back_s = 40'(qs_reg) * 40'(SIN_K);
    assign back_c = 40'(qc_reg) * 40'(COS_K);
    assign qs_fix = (back_s > 40'(ps2_reg)) ? qs_reg - 32'd1 : qs_reg;
    assign qc_fix = (back_c > 40'(pc2_reg)) ? qc_reg - 32'd1 : qc_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg  <= din;
            ps1_reg <= prod_s[61:30];
            pc1_reg <= prod_c[61:30];

            s2_reg  <= s1_reg;
            ps2_reg <= ps1_reg;
            pc2_reg <= pc1_reg;
            qs_reg  <= est_s[63:32];
            qc_reg  <= est_c[63:32];

            dout.x2   <= s2_reg.x2;
            dout.sneg <= s2_reg.sneg;
            dout.cneg <= s2_reg.cneg;

            dout.term_c <= qc_fix[30:0];
            if (SUB)
                dout.sum_c <= s2_reg.sum_c - $signed({3'b000, qc_fix[30:0]});
            else
                dout.sum_c <= s2_reg.sum_c + $signed({3'b000, qc_fix[30:0]});

            if (!SIN_ON)
            begin
                dout.term_s <= s2_reg.term_s;
                dout.sum_s  <= s2_reg.sum_s;
            end
            else
            begin
                dout.term_s <= qs_fix[30:0];
                if (SUB)
                    dout.sum_s <= s2_reg.sum_s - $signed({3'b000, qs_fix[30:0]});
                else
                    dout.sum_s <= s2_reg.sum_s + $signed({3'b000, qs_fix[30:0]});
            end
        end
    end

endmodule

// ===== hdl/hlpi_sincos.sv =====
// ----------------------------------------------------------------------------
// hlpi_sincos
// Pipelined sine and cosine of a Q14 angle: fold to [0, pi/2], Taylor cells, round.
// ----------------------------------------------------------------------------
module hlpi_sincos
    import hlpi_pkg::*;
#(
    parameter int FRAC = 14
)
(
    input  logic                   clk,
    input  logic                   adv,
    input  logic [15:0]            theta,
    output logic signed [FRAC+1:0] sin_val,
    output logic signed [FRAC+1:0] cos_val
);

    localparam logic [30:0] ROUND_ADD = 31'(1) << (29 - FRAC);
    localparam int          RSH       = 30 - FRAC;

    logic [31:0] t1_reg;
    logic        sneg1_reg, cneg1_reg;
    logic [30:0] t2_reg;
    logic        sneg2_reg, cneg2_reg;
    taylor_t     chain [0:COS_STEPS];
    logic [FRAC:0] ms_reg, mc_reg;
    logic          sneg_reg, cneg_reg;

    logic [31:0] t0;
    logic [31:0] t2_fold;
    logic [61:0] sq;
    logic [30:0] cl_s, cl_c;
    logic [30:0] rs, rc;

    assign t0      = {theta, 16'h0000};
    assign t2_fold = PI_Q30 - t1_reg;
    assign sq      = 62'(t2_reg) * 62'(t2_reg);

    always_comb
    begin
        if (chain[COS_STEPS].sum_s < 0)
            cl_s = '0;
        else if (chain[COS_STEPS].sum_s > 34'(ONE_Q30))
            cl_s = ONE_Q30;
        else
            cl_s = chain[COS_STEPS].sum_s[30:0];
        if (chain[COS_STEPS].sum_c < 0)
            cl_c = '0;
        else if (chain[COS_STEPS].sum_c > 34'(ONE_Q30))
            cl_c = ONE_Q30;
        else
            cl_c = chain[COS_STEPS].sum_c[30:0];
    end

    assign rs = (cl_s + ROUND_ADD) >> RSH;
    assign rc = (cl_c + ROUND_ADD) >> RSH;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (t0 >= PI_Q30)
            begin
                t1_reg    <= t0 - PI_Q30;
                sneg1_reg <= 1'b1;
                cneg1_reg <= 1'b1;
            end
            else
            begin
                t1_reg    <= t0;
                sneg1_reg <= 1'b0;
                cneg1_reg <= 1'b0;
            end

            sneg2_reg <= sneg1_reg;
            if (t1_reg > HALF_PI_Q30)
            begin
                t2_reg    <= t2_fold[30:0];
                cneg2_reg <= !cneg1_reg;
            end
            else
            begin
                t2_reg    <= t1_reg[30:0];
                cneg2_reg <= cneg1_reg;
            end

            chain[0].x2     <= sq[61:30];
            chain[0].term_s <= t2_reg;
            chain[0].sum_s  <= $signed({3'b000, t2_reg});
            chain[0].term_c <= ONE_Q30;
            chain[0].sum_c  <= $signed({3'b000, ONE_Q30});
            chain[0].sneg   <= sneg2_reg;
            chain[0].cneg   <= cneg2_reg;

            ms_reg   <= rs[FRAC:0];
            mc_reg   <= rc[FRAC:0];
            sneg_reg <= chain[COS_STEPS].sneg;
            cneg_reg <= chain[COS_STEPS].cneg;

            sin_val <= sneg_reg ? -$signed({1'b0, ms_reg}) : $signed({1'b0, ms_reg});
            cos_val <= cneg_reg ? -$signed({1'b0, mc_reg}) : $signed({1'b0, mc_reg});
        end
    end

    for (genvar k = 1; k <= COS_STEPS; k++)
    begin : g_cell
        hlpi_trig_cell #(.STEP(k)) u_cell (
            .clk  (clk),
            .adv  (adv),
            .din  (chain[k-1]),
            .dout (chain[k])
        );
    end

endmodule

// ===== hdl/hlpi_div_cell.sv =====
// ----------------------------------------------------------------------------
// hlpi_div_cell
// One restoring divide step: shift in a dividend bit, trial subtract, quotient bit.
// ----------------------------------------------------------------------------
module hlpi_div_cell #(
    parameter int DM_W = 33,
    parameter int QW   = 34
)
(
    input  logic            clk,
    input  logic            adv,
    input  logic [DM_W:0]   rem_in,
    input  logic [QW-1:0]   num_in,
    input  logic [QW-1:0]   quo_in,
    input  logic [DM_W-1:0] dm_in,
    output logic [DM_W:0]   rem_out,
    output logic [QW-1:0]   num_out,
    output logic [QW-1:0]   quo_out,
    output logic [DM_W-1:0] dm_out
);

    logic [DM_W+1:0] trial;
    logic [DM_W+1:0] diff;
    logic            take;

    assign trial = {rem_in, num_in[QW-1]};
    assign diff  = trial - (DM_W+2)'(dm_in);
    assign take  = (trial >= (DM_W+2)'(dm_in));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_out <= take ? diff[DM_W:0] : trial[DM_W:0];
            num_out <= {num_in[QW-2:0], 1'b0};
            quo_out <= {quo_in[QW-2:0], take};
            dm_out  <= dm_in;
        end
    end

endmodule
